/* rtl/core/single_wire_sensor_frame_decoder_defines.svh */
// -----------------------------------------------------------------------------
// Single-wire sensor frame decoder: assertion macros
// Concurrent check helpers shared by the RTL of the frame decoder.
// -----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_SENSOR_FRAME_DECODER_DEFINES_SVH
`define SINGLE_WIRE_SENSOR_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SWSFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("swsfd check failed");

// Next-cycle implication, checked outside reset
`define SWSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("swsfd check failed");

`endif

/* rtl/core/swsfd_pkg.sv */
// -----------------------------------------------------------------------------
// Single-wire sensor frame decoder package
// Shared constants and payload types.
// -----------------------------------------------------------------------------
package swsfd_pkg;

	localparam int FRAME_LENGTH = 40;
	localparam int CNT_W        = 6;

	localparam logic [7:0]       THRESH_RESET = 8'd30;
	localparam logic [CNT_W-1:0] LAST_BIT     = CNT_W'(FRAME_LENGTH - 1);
	localparam logic [CNT_W-1:0] FULL_COUNT   = CNT_W'(FRAME_LENGTH);

	typedef logic [FRAME_LENGTH-1:0] frame_t;

	typedef struct packed {
		logic [7:0] pulse_width;
		logic       frame_start;
	} item_t;

	typedef struct packed {
		logic [15:0]        humidity_tenths;
		logic signed [15:0] temperature_tenths;
		logic               checksum_ok;
	} result_t;

endpackage

/* rtl/core/swsfd_if.sv */
// -----------------------------------------------------------------------------
// Single-wire sensor frame decoder channels
// Valid/ready channels for bit requests, results and the threshold write.
// -----------------------------------------------------------------------------
interface swsfd_bit_if;
	logic       valid;
	logic       ready;
	logic [7:0] pulse_width;
	logic       frame_start;

	modport source (output valid, output pulse_width, output frame_start, input ready);
	modport sink   (input valid, input pulse_width, input frame_start, output ready);
endinterface

interface swsfd_result_if;
	logic               valid;
	logic               ready;
	logic [15:0]        humidity_tenths;
	logic signed [15:0] temperature_tenths;
	logic               checksum_ok;

	modport source (output valid, output humidity_tenths, output temperature_tenths,
		output checksum_ok, input ready);
	modport sink   (input valid, input humidity_tenths, input temperature_tenths,
		input checksum_ok, output ready);
endinterface

interface swsfd_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] one_threshold;

	modport source (output valid, output one_threshold, input ready);
	modport sink   (input valid, input one_threshold, output ready);
endinterface

/* rtl/core/swsfd_assembler.sv */
// -----------------------------------------------------------------------------
// Frame assembler
// Slices one pulse width into a bit and shifts it into the frame register.
// -----------------------------------------------------------------------------
`include "single_wire_sensor_frame_decoder_defines.svh"

module swsfd_assembler
	import swsfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  item_t      item,
	input  logic [7:0] threshold,
	output logic       done,
	output frame_t     frame_next
);

	frame_t           frame_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             bit_val;

	always_comb begin
		bit_val    = (item.pulse_width >= threshold);
		frame_next = {frame_q[FRAME_LENGTH-2:0], bit_val};
		// a frame start drops whatever was collected so far
		count_next = item.frame_start ? CNT_W'(1) : count_q + CNT_W'(1);
		done       = (count_next == FULL_COUNT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			count_q <= '0;
		end else if (advance) begin
			frame_q <= frame_next;
			count_q <= done ? '0 : count_next;
		end
	end

	`SWSFD_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, count_q < FULL_COUNT)
	`SWSFD_ASSERT_NOW(a_done_on_last, clk, arst_n, done, (count_q == LAST_BIT) && !item.frame_start)
	`SWSFD_ASSERT_NEXT(a_count_step, clk, arst_n, advance && !done && !item.frame_start,
		count_q == $past(count_q) + CNT_W'(1))

endmodule

/* rtl/core/swsfd_unpack.sv */
// -----------------------------------------------------------------------------
// Frame unpacker
// Splits a full frame into humidity, signed temperature and checksum flag.
// -----------------------------------------------------------------------------
module swsfd_unpack
	import swsfd_pkg::*;
(
	input  frame_t  frame,
	output result_t res
);

	logic [15:0] traw;
	logic [15:0] mag;
	logic [7:0]  sum;

	always_comb begin
		traw = frame[23:8];
		mag  = {1'b0, traw[14:0]};
		// convert sign and magnitude; negative zero comes out as zero
		res.humidity_tenths    = frame[39:24];
		res.temperature_tenths = traw[15] ? -mag : mag;
		sum = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
		res.checksum_ok        = (sum == frame[7:0]);
	end

endmodule

/* rtl/core/single_wire_sensor_frame_decoder.sv */
// -----------------------------------------------------------------------------
// Single-wire sensor frame decoder
// Turns measured bit pulse widths into humidity, temperature and checksum.
// -----------------------------------------------------------------------------
// Usage:
//   bit_in  - one request per data bit: the pulse width in microseconds and a
//             frame_start flag that marks the first bit of a new frame.
//   result  - one request per completed 40-bit frame: humidity and
//             temperature in tenths plus a checksum-ok flag.
//   cfg     - threshold write; a width at or above it decodes as one. Write
//             only while the block is idle. Always ready.
// Timing:
//   A bit request is registered on acceptance, then decoded and shifted in as
//   the input stage advances; the result register takes the frame result as
//   the last bit advances. One bit request is taken every cycle unless a
//   result stalls, set by the single input register feeding the frame register.
// Reset:
//   arst_n clears the frame, the bit count and all valids, and loads the
//   threshold with 30 us.
// Stall:
//   While a result waits and result.ready is low, hold the input register;
//   bit_in.ready drops once it is full, so one more request is taken at most.
// -----------------------------------------------------------------------------
`include "single_wire_sensor_frame_decoder_defines.svh"

module single_wire_sensor_frame_decoder
	import swsfd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	swsfd_bit_if.sink      bit_in,
	swsfd_result_if.source result,
	swsfd_cfg_if.sink      cfg
);

	logic       valid_s1;
	item_t      item_s1;
	logic [7:0] thresh_q;
	logic       res_valid_q;
	result_t    res_q;

	logic    advance;
	logic    done;
	frame_t  frame_next;
	result_t res_next;

	// advance the input stage whenever the output register is free or draining
	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign bit_in.ready = !valid_s1 || advance;
	assign cfg.ready    = 1'b1;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg.valid) begin
			thresh_q <= cfg.one_threshold;
		end
	end

	// input stage: hold the accepted bit request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bit_in.ready) begin
			valid_s1 <= bit_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bit_in.valid && bit_in.ready) begin
			item_s1.pulse_width <= bit_in.pulse_width;
			item_s1.frame_start <= bit_in.frame_start;
		end
	end

	swsfd_assembler u_assembler (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item       (item_s1),
		.threshold  (thresh_q),
		.done       (done),
		.frame_next (frame_next)
	);

	swsfd_unpack u_unpack (
		.frame (frame_next),
		.res   (res_next)
	);

	// result register: load on the frame's last bit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && done) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && done) begin
			res_q <= res_next;
		end
	end

	assign result.valid              = res_valid_q;
	assign result.humidity_tenths    = res_q.humidity_tenths;
	assign result.temperature_tenths = res_q.temperature_tenths;
	assign result.checksum_ok        = res_q.checksum_ok;

	`SWSFD_ASSERT_NOW(a_stall_blocks_input, clk, arst_n,
		valid_s1 && res_valid_q && !result.ready, !bit_in.ready)
	`SWSFD_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, bit_in.valid && bit_in.ready, valid_s1)
	`SWSFD_ASSERT_NOW(a_result_from_s1, clk, arst_n, $rose(res_valid_q), $past(valid_s1))

endmodule
